// ----- src/srp_pkg.sv -----
`default_nettype none
package srp_pkg;

    localparam int MaxNodes  = 256;
    localparam int MaxSide   = 4096;
    localparam int SlotW     = $clog2(MaxNodes);
    localparam int CntW      = SlotW + 1;
    localparam int CoordW    = 13;

    localparam logic [CntW-1:0]   MaxCnt    = CntW'(MaxNodes);
    localparam logic [CoordW-1:0] MaxSideV  = CoordW'(MaxSide);
    localparam logic [CoordW-1:0] ResetSide = CoordW'(512);

    // configuration register indexes
    localparam logic CfgAtlasW = 1'b0;
    localparam logic CfgAtlasH = 1'b1;

    typedef enum logic [1:0] {
        STAT_PLACED  = 2'd0,
        STAT_NOFIT   = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_CLEARED = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        OP_HOLD,
        OP_FLAT,
        OP_LOAD,
        OP_WIN,
        OP_SHIFT,
        OP_INS,
        OP_REMOVE,
        OP_TRIM,
        OP_MERGE
    } t_cell_op;

    typedef struct packed {
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic [CoordW-1:0] w;
    } t_node;

    typedef struct packed {
        logic              v;
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic [CoordW-1:0] w;
    } t_probe;

    typedef struct packed {
        t_cell_op          op;
        logic [SlotW-1:0]  pos;
        logic [CntW-1:0]   ppos;
        logic [CntW-1:0]   cnt;
        logic              last;
        logic [CoordW-1:0] rw;
        logic [CoordW-1:0] rh;
        logic [CoordW-1:0] ah;
        logic [CoordW:0]   lim;
        logic [CoordW-1:0] front;
        logic [CoordW-1:0] nx;
        logic [CoordW-1:0] top;
        logic [CoordW-1:0] aw;
    } t_cell_ctl;

    typedef struct packed {
        logic cov;
        logic hit;
    } t_cell_flg;

endpackage
`default_nettype wire

// ----- src/srp_req_if.sv -----
`default_nettype none
interface srp_req_if import srp_pkg::*;;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [CoordW-1:0] rect_width;
    logic [CoordW-1:0] rect_height;

    modport src (output valid, output cmd, output rect_width, output rect_height,
                 input ready);
    modport snk (input valid, input cmd, input rect_width, input rect_height,
                 output ready);
endinterface
`default_nettype wire

// ----- src/srp_rsp_if.sv -----
`default_nettype none
interface srp_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [11:0] pos_x;
    logic [11:0] pos_y;

    modport src (output valid, output status, output pos_x, output pos_y, input ready);
    modport snk (input valid, input status, input pos_x, input pos_y, output ready);
endinterface
`default_nettype wire

// ----- src/skyline_rect_packer_unit.sv -----
`default_nettype none
// skyline rectangle packer: lowest top first, on equal tops the narrower node,
// then the earlier start. the skyline lives in a row of MaxNodes cells, one
// node (x, top y, width) per cell, kept in x order and contiguous from x = 0.
// a place request runs: a load step, window steps in which node copies slide
// down the row so every cell sees all nodes to its right and keeps the highest
// top under its span, shift steps in which the per-cell results slide out of
// cell 0 into the best-fit compare, a result step, then insert, trim (covered
// nodes removed one at a time, then the next node cut back) and two merge
// checks, right then left. a clear or a zero sized request goes straight to
// the result step. one request is worked at a time; the input is ready only
// in idle. the result sits in an output register, so the next request may be
// taken while it still waits for its transfer. no fit and store full leave
// the skyline untouched. atlas size changes apply to the fit tests at once,
// the skyline width only on the next clear.
module skyline_rect_packer_unit import srp_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [CoordW-1:0] i_cfg_data,
    srp_req_if.snk                 i_req,
    srp_rsp_if.src                 o_rsp
);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_LOAD = 9'b000000010,
        ST_WIN  = 9'b000000100,
        ST_SEL  = 9'b000001000,
        ST_DEC  = 9'b000010000,
        ST_INS  = 9'b000100000,
        ST_TRIM = 9'b001000000,
        ST_MRGR = 9'b010000000,
        ST_MRGL = 9'b100000000
    } t_state;

    t_state            r_state, n_state;
    logic [SlotW-1:0]  r_t;
    logic [CntW-1:0]   r_count;
    logic [CoordW-1:0] r_end;
    logic [CoordW-1:0] r_aw, r_ah;
    logic [CoordW-1:0] r_rw, r_rh;
    logic              r_found;
    logic [SlotW-1:0]  r_bidx;
    logic [CoordW:0]   r_btop;
    logic [CoordW-1:0] r_bw, r_bx, r_by;
    t_status           r_status;
    logic              r_ovalid;
    t_status           r_ostatus;
    logic [11:0]       r_ox, r_oy;

    logic [CoordW-1:0] aw_eff, ah_eff;
    logic [CoordW:0]   lim;
    logic [CoordW-1:0] front;
    logic              req_xfer;
    logic              last_t;
    t_cell_ctl         w_ctl;

    t_node     w_node    [MaxNodes];
    t_node     w_node_dn [MaxNodes];
    t_node     w_node_up [MaxNodes];
    t_probe    w_probe   [MaxNodes];
    t_probe    w_probe_up[MaxNodes];
    t_cell_flg w_flg     [MaxNodes];
    logic [MaxNodes-1:0] w_cov, w_hit;
    logic              any_cov, any_hit;

    // best-fit compare on the candidate leaving cell 0
    t_probe            cand;
    logic [CoordW:0]   cand_top;
    logic              better;
    logic              n_found;

    // register values out of range are clamped
    always_comb begin
        aw_eff = (r_aw == '0) ? CoordW'(1) : ((r_aw > MaxSideV) ? MaxSideV : r_aw);
        ah_eff = (r_ah == '0) ? CoordW'(1) : ((r_ah > MaxSideV) ? MaxSideV : r_ah);
        // a span must end inside both the atlas and the current skyline
        lim    = (aw_eff < r_end) ? {1'b0, aw_eff} : {1'b0, r_end};
        front  = r_bx + r_rw;
    end

    assign req_xfer    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_IDLE);
    assign last_t      = ({1'b0, r_t} == (r_count - CntW'(1)));

    always_comb begin
        cand     = w_probe[0];
        cand_top = {1'b0, cand.y} + {1'b0, r_rh};
        // on equal tops keep the earlier start unless this node is narrower
        better   = cand.v && (!r_found || (cand_top < r_btop) ||
                              ((cand_top == r_btop) && (cand.w < r_bw)));
        n_found  = r_found || better;
    end

    // broadcast control for the cell row
    always_comb begin
        w_ctl.op    = OP_HOLD;
        w_ctl.pos   = r_bidx;
        w_ctl.ppos  = {1'b0, r_bidx} + CntW'(1);
        w_ctl.cnt   = r_count;
        w_ctl.last  = last_t;
        w_ctl.rw    = r_rw;
        w_ctl.rh    = r_rh;
        w_ctl.ah    = ah_eff;
        w_ctl.lim   = lim;
        w_ctl.front = front;
        w_ctl.nx    = r_bx;
        w_ctl.top   = r_btop[CoordW-1:0];
        w_ctl.aw    = aw_eff;
        unique case (r_state)
            ST_IDLE: begin
                if (req_xfer && i_req.cmd) begin
                    w_ctl.op = OP_FLAT;
                end
            end
            ST_LOAD: w_ctl.op = OP_LOAD;
            ST_WIN:  w_ctl.op = OP_WIN;
            ST_SEL:  w_ctl.op = OP_SHIFT;
            ST_DEC:  w_ctl.op = OP_HOLD;
            ST_INS:  w_ctl.op = OP_INS;
            ST_TRIM: w_ctl.op = any_cov ? OP_REMOVE : OP_TRIM;
            ST_MRGR: w_ctl.op = any_hit ? OP_MERGE : OP_HOLD;
            ST_MRGL: begin
                // left neighbor; at the left edge ppos wraps to a slot no cell has
                w_ctl.pos  = r_bidx - SlotW'(1);
                w_ctl.ppos = {1'b0, r_bidx} - CntW'(1);
                w_ctl.op   = any_hit ? OP_MERGE : OP_HOLD;
            end
            default: w_ctl.op = OP_HOLD;
        endcase
    end

    // the cell row
    for (genvar g = 0; g < MaxNodes; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_node_dn[g] = w_node[g];
        end else begin : g_mid_dn
            assign w_node_dn[g] = w_node[g-1];
        end
        if (g == MaxNodes - 1) begin : g_last
            assign w_node_up[g]  = w_node[g];
            assign w_probe_up[g] = '0;
        end else begin : g_mid_up
            assign w_node_up[g]  = w_node[g+1];
            assign w_probe_up[g] = w_probe[g+1];
        end

        srp_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_slot     (SlotW'(g)),
            .i_ctl      (w_ctl),
            .i_node_dn  (w_node_dn[g]),
            .i_node_up  (w_node_up[g]),
            .i_probe_up (w_probe_up[g]),
            .o_node     (w_node[g]),
            .o_probe    (w_probe[g]),
            .o_flg      (w_flg[g])
        );

        assign w_cov[g] = w_flg[g].cov;
        assign w_hit[g] = w_flg[g].hit;
    end

    assign any_cov = |w_cov;
    assign any_hit = |w_hit;

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (req_xfer) begin
                    if (i_req.cmd || (i_req.rect_width == '0) || (i_req.rect_height == '0)) begin
                        n_state = ST_DEC;
                    end else begin
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_LOAD: n_state = ST_WIN;
            ST_WIN:  if (last_t) n_state = ST_SEL;
            ST_SEL:  if (last_t) n_state = ST_DEC;
            ST_DEC: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_state = (r_status == STAT_PLACED) ? ST_INS : ST_IDLE;
                end
            end
            ST_INS:  n_state = ST_TRIM;
            ST_TRIM: if (!any_cov) n_state = ST_MRGR;
            ST_MRGR: n_state = ST_MRGL;
            ST_MRGL: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= CntW'(1);
            r_end    <= ResetSide;
            r_aw     <= ResetSide;
            r_ah     <= ResetSide;
            r_ovalid <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CfgAtlasW: r_aw <= i_cfg_data;
                    CfgAtlasH: r_ah <= i_cfg_data;
                    default: ;
                endcase
            end

            // the result cycle reloads the output itself
            if (r_ovalid && o_rsp.ready && (r_state != ST_DEC)) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (req_xfer) begin
                        r_rw <= i_req.rect_width;
                        r_rh <= i_req.rect_height;
                        if (i_req.cmd) begin
                            r_count  <= CntW'(1);
                            r_end    <= aw_eff;
                            r_status <= STAT_CLEARED;
                        end else begin
                            r_status <= STAT_NOFIT;
                        end
                    end
                end
                ST_LOAD: begin
                    r_t     <= '0;
                    r_found <= 1'b0;
                end
                ST_WIN: begin
                    r_t <= last_t ? '0 : r_t + SlotW'(1);
                end
                ST_SEL: begin
                    r_t     <= r_t + SlotW'(1);
                    r_found <= n_found;
                    if (better) begin
                        r_bidx <= r_t;
                        r_btop <= cand_top;
                        r_bw   <= cand.w;
                        r_bx   <= cand.x;
                        r_by   <= cand.y;
                    end
                    if (last_t) begin
                        r_status <= !n_found ? STAT_NOFIT :
                                    ((r_count == MaxCnt) ? STAT_FULL : STAT_PLACED);
                    end
                end
                ST_DEC: begin
                    if (!r_ovalid || o_rsp.ready) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= r_status;
                        if (r_status == STAT_PLACED) begin
                            r_ox <= r_bx[11:0];
                            r_oy <= r_by[11:0];
                        end else begin
                            r_ox <= '0;
                            r_oy <= '0;
                        end
                    end
                end
                ST_INS:  r_count <= r_count + CntW'(1);
                ST_TRIM: if (any_cov) r_count <= r_count - CntW'(1);
                ST_MRGR: if (any_hit) r_count <= r_count - CntW'(1);
                ST_MRGL: if (any_hit) r_count <= r_count - CntW'(1);
                default: ;
            endcase
        end
    end

    assign o_rsp.valid  = r_ovalid;
    assign o_rsp.status = r_ostatus;
    assign o_rsp.pos_x  = r_ox;
    assign o_rsp.pos_y  = r_oy;

    // node count stays within the store
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= MaxCnt))
        else $error("node count out of range");

    // insert always adds exactly one node
    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INS) |=> (r_count == ($past(r_count) + CntW'(1))))
        else $error("insert did not grow node count");

    // a result appears only out of the result cycle
    a_rsp_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == ST_DEC))
        else $error("result raised outside result cycle");

    // a placed rectangle never comes with a no-fit search
    a_place_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INS) |-> r_found)
        else $error("insert without a fitting candidate");

endmodule
`default_nettype wire

// ----- src/srp_cell.sv -----
`default_nettype none
module srp_cell import srp_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [SlotW-1:0] i_slot,
    input  wire t_cell_ctl        i_ctl,
    input  wire t_node            i_node_dn,
    input  wire t_node            i_node_up,
    input  wire t_probe           i_probe_up,
    output t_node                 o_node,
    output t_probe                o_probe,
    output t_cell_flg             o_flg
);

    t_node             r_node;
    t_probe            r_probe;
    logic [CoordW-1:0] r_ymax;

    logic [CntW-1:0]   slot_w;
    logic              live;
    logic              above;
    logic              here;
    logic              nxt;
    logic [CoordW:0]   right;
    logic [CoordW:0]   span_end;
    logic              inwin;
    logic [CoordW-1:0] nymax;
    logic [CoordW:0]   ntop;
    logic              fit;

    always_comb begin
        slot_w   = {1'b0, i_slot};
        live     = slot_w < i_ctl.cnt;
        above    = i_slot > i_ctl.pos;
        here     = i_slot == i_ctl.pos;
        nxt      = slot_w == ({1'b0, i_ctl.pos} + CntW'(1));
        right    = {1'b0, r_node.x} + {1'b0, r_node.w};
        span_end = {1'b0, r_node.x} + {1'b0, i_ctl.rw};
        // window covers every node that starts left of the span end
        inwin    = r_probe.v && ({1'b0, r_probe.x} < span_end);
        nymax    = (inwin && (r_probe.y > r_ymax)) ? r_probe.y : r_ymax;
        ntop     = {1'b0, nymax} + {1'b0, i_ctl.rh};
        fit      = live && (span_end <= i_ctl.lim) && (ntop <= {1'b0, i_ctl.ah});
        o_flg.cov = above && live && (right <= {1'b0, i_ctl.front});
        o_flg.hit = (slot_w == i_ctl.ppos) && live && (r_node.y == i_ctl.top);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            if (i_slot == '0) begin
                r_node <= '{x: '0, y: '0, w: ResetSide};
            end
        end else begin
            case (i_ctl.op)
                OP_HOLD: ;
                OP_FLAT: begin
                    if (i_slot == '0) begin
                        r_node <= '{x: '0, y: '0, w: i_ctl.aw};
                    end
                end
                OP_LOAD: begin
                    r_probe <= '{v: live, x: r_node.x, y: r_node.y, w: r_node.w};
                    r_ymax  <= '0;
                end
                OP_WIN: begin
                    r_ymax <= nymax;
                    if (i_ctl.last) begin
                        r_probe <= '{v: fit, x: r_node.x, y: nymax, w: r_node.w};
                    end else begin
                        r_probe <= i_probe_up;
                    end
                end
                OP_SHIFT: r_probe <= i_probe_up;
                OP_INS: begin
                    if (above) begin
                        r_node <= i_node_dn;
                    end else if (here) begin
                        r_node <= '{x: i_ctl.nx, y: i_ctl.top, w: i_ctl.rw};
                    end
                end
                OP_REMOVE: begin
                    if (above) begin
                        r_node <= i_node_up;
                    end
                end
                OP_TRIM: begin
                    if (nxt && (r_node.x < i_ctl.front)) begin
                        r_node.x <= i_ctl.front;
                        r_node.w <= r_node.w - (i_ctl.front - r_node.x);
                    end
                end
                OP_MERGE: begin
                    if (here) begin
                        r_node.w <= r_node.w + i_node_up.w;
                    end else if (above) begin
                        r_node <= i_node_up;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_node  = r_node;
    assign o_probe = r_probe;

endmodule
`default_nettype wire
